/* rtl/core/sdcp_pkg.sv */
// Shared types, constants and the quarter-wave sine ROM of the dither PWM unit.
`default_nettype none

package sdcp_pkg;

  localparam int unsigned SP_W          = 12;
  localparam int unsigned CMP_W         = 11;
  localparam int unsigned DITH_W        = 13;
  localparam int unsigned PHASE_W       = 16;
  localparam int unsigned AMP_W         = 12;
  localparam int unsigned CFG_ADDR_W    = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned IN_TDATA_W    = 24;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned FULL_SCALE_MA = 2500;
  localparam int unsigned SINE_BITS     = 8;
  localparam int unsigned SINE_N        = 1 << SINE_BITS;
  localparam int unsigned SINE_IDX_W    = SINE_BITS + 1;
  localparam int unsigned SINE_W        = 15;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_TICKS = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DITHER_AMP   = 2'd2;

  typedef struct packed {
    logic [SP_W-1:0]       ch1_setpoint;
    logic [SP_W-1:0]       ch2_setpoint;
    logic                  dith_on;
    logic                  neg;
    logic [SINE_IDX_W-1:0] idx;
  } tick_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DITHER,
    BK_SCALE,
    BK_DIV,
    BK_HOLD
  } back_state_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:SINE_N];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t3;
    logic [63:0] t5;
    logic [63:0] t7;
    logic [63:0] t9;
    logic [63:0] s;
    logic [63:0] q;
    for (int k = 0; k <= int'(SINE_N); k++) begin
      x  = (64'(k) * HALF_PI_Q30) / 64'(SINE_N);
      x2 = (x * x) >> 30;
      t3 = ((x * x2) >> 30) / 64'd6;
      t5 = ((t3 * x2) >> 30) / 64'd20;
      t7 = ((t5 * x2) >> 30) / 64'd42;
      t9 = ((t7 * x2) >> 30) / 64'd72;
      s  = x - t3 + t5 - t7 + t9;
      q  = (s + 64'd16384) >> 15;
      rom[k] = (q > 64'd32767) ? 15'd32767 : q[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

/* rtl/core/sdcp_queue.sv */
// Two-entry queue of classified ticks between front and back.
`default_nettype none

module sdcp_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  sdcp_pkg::tick_entry_t push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 head_valid,
  output sdcp_pkg::tick_entry_t head_data
);
  import sdcp_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_entry_t      mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sdcp_front.sv */
// Front end: configuration registers, tick accept, phase and tick counter update.
`default_nettype none

module sdcp_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [sdcp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [sdcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [sdcp_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire                               q_full,
  output logic                              q_push,
  output sdcp_pkg::tick_entry_t             q_data,
  output logic [sdcp_pkg::AMP_W-1:0]        dither_amp
);
  import sdcp_pkg::*;

  logic [PHASE_W-1:0] phase_step_r;
  logic [PHASE_W-1:0] period_ticks_r;
  logic [AMP_W-1:0]   amp_r;
  logic [PHASE_W-1:0] phase_r;
  logic [PHASE_W-1:0] count_r;
  logic               dith_on;
  logic [PHASE_W-1:0] phase_adv;
  logic [PHASE_W-1:0] count_adv;
  logic               wrap;
  logic [1:0]         quad;
  logic [SINE_IDX_W-1:0] idx_raw;
  logic               accept;

  assign in_tready  = !q_full;
  assign accept     = in_tvalid && !q_full;
  assign dither_amp = amp_r;

  assign dith_on   = (phase_step_r != '0) && (amp_r != '0);
  assign phase_adv = phase_r + phase_step_r;
  assign count_adv = count_r + 1'b1;
  assign wrap      = (count_adv >= period_ticks_r);
  assign quad      = phase_adv[PHASE_W-1 -: 2];
  assign idx_raw   = {1'b0, phase_adv[PHASE_W-3 -: SINE_BITS]};

  always_comb begin
    q_push               = accept;
    q_data.ch1_setpoint  = in_tdata[SP_W-1:0];
    q_data.ch2_setpoint  = in_tdata[2*SP_W-1:SP_W];
    q_data.dith_on       = dith_on;
    q_data.neg           = quad[1];
    q_data.idx           = quad[0] ? (SINE_IDX_W'(SINE_N) - idx_raw) : idx_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r   <= '0;
      period_ticks_r <= '1;
      amp_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PHASE_STEP:   phase_step_r   <= cfg_wdata[PHASE_W-1:0];
        REG_PERIOD_TICKS: period_ticks_r <= cfg_wdata[PHASE_W-1:0];
        REG_DITHER_AMP:   amp_r          <= cfg_wdata[AMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      count_r <= '0;
    end else if (accept && dith_on) begin
      phase_r <= wrap ? '0 : phase_adv;
      count_r <= wrap ? '0 : count_adv;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sdcp_back.sv */
// Back end: sine lookup, dither, drive clamp, duty scaling and output register.
`default_nettype none

module sdcp_back #(
  parameter int unsigned PWM_PERIOD = 1023
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire  [sdcp_pkg::AMP_W-1:0]        dither_amp,
  input  wire                               q_valid,
  input  sdcp_pkg::tick_entry_t             q_head,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [sdcp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sdcp_pkg::*;

  localparam int unsigned SCALE    = PWM_PERIOD + 1;
  localparam int unsigned SCALE_W  = $clog2(SCALE + 1);
  localparam int unsigned DRIVE_W  = 12;
  localparam int unsigned PROD_W   = DRIVE_W + SCALE_W;
  localparam int unsigned RECIP_SH = PROD_W + 12;
  localparam int unsigned RECIP_W  = PROD_W + 1;
  localparam int unsigned QPROD_W  = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(FULL_SCALE_MA) - 64'd1) / 64'(FULL_SCALE_MA));
  localparam int unsigned MAG_W    = AMP_W + SINE_W;
  localparam int unsigned PAD_W    = OUT_TDATA_W - 2 * CMP_W - DITH_W;

  back_state_t state_r;
  back_state_t state_nxt;

  tick_entry_t          ent_r;
  logic [SINE_W-1:0]    sine_r;
  logic [MAG_W-1:0]     magprod_r;
  logic [DITH_W-1:0]    dither_r;
  logic [DRIVE_W-1:0]   drive1_r;
  logic [DRIVE_W-1:0]   drive2_r;
  logic [PROD_W-1:0]    div1_r;
  logic [PROD_W-1:0]    div2_r;
  logic [CMP_W-1:0]     quo1_r;
  logic [CMP_W-1:0]     quo2_r;
  logic                 out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [AMP_W-1:0]     amp_sat;
  logic [MAG_W-1:0]     mag_sum;
  logic [DITH_W-1:0]    dither_nxt;
  logic [DRIVE_W-1:0]   drive1_nxt;
  logic [DRIVE_W-1:0]   drive2_nxt;
  logic [QPROD_W-1:0]   qprod1;
  logic [QPROD_W-1:0]   qprod2;
  logic                 out_free;

  function automatic logic [DRIVE_W-1:0] clamp_drive(input logic [SP_W-1:0] sp,
                                                     input logic [DITH_W-1:0] dith);
    logic signed [DRIVE_W+1:0] sum;
    logic [DRIVE_W-1:0]        res;
    sum = $signed({2'b00, sp}) + $signed({dith[DITH_W-1], dith});
    if (sp == '0 || sum < 0) begin
      res = '0;
    end else if (sum > $signed((DRIVE_W+2)'(FULL_SCALE_MA))) begin
      res = DRIVE_W'(FULL_SCALE_MA);
    end else begin
      res = sum[DRIVE_W-1:0];
    end
    return res;
  endfunction

  assign amp_sat  = (dither_amp > AMP_W'(FULL_SCALE_MA)) ? AMP_W'(FULL_SCALE_MA) : dither_amp;
  assign mag_sum  = magprod_r + MAG_W'(16384);
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    if (!ent_r.dith_on) begin
      dither_nxt = '0;
    end else if (ent_r.neg) begin
      dither_nxt = -{1'b0, mag_sum[MAG_W-1 -: DRIVE_W]};
    end else begin
      dither_nxt = {1'b0, mag_sum[MAG_W-1 -: DRIVE_W]};
    end
  end

  assign drive1_nxt = clamp_drive(ent_r.ch1_setpoint, dither_nxt);
  assign drive2_nxt = clamp_drive(ent_r.ch2_setpoint, dither_nxt);

  assign qprod1 = QPROD_W'(div1_r) * QPROD_W'(RECIP_C);
  assign qprod2 = QPROD_W'(div2_r) * QPROD_W'(RECIP_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:    state_nxt = BK_DITHER;
      BK_DITHER: state_nxt = BK_SCALE;
      BK_SCALE:  state_nxt = BK_DIV;
      BK_DIV:    state_nxt = BK_HOLD;
      BK_HOLD: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        ent_r  <= q_head;
        sine_r <= SINE_ROM[q_head.idx];
      end
      BK_MUL: begin
        magprod_r <= MAG_W'(amp_sat) * MAG_W'(sine_r);
      end
      BK_DITHER: begin
        dither_r <= dither_nxt;
        drive1_r <= drive1_nxt;
        drive2_r <= drive2_nxt;
      end
      BK_SCALE: begin
        div1_r <= PROD_W'(drive1_r) * PROD_W'(SCALE);
        div2_r <= PROD_W'(drive2_r) * PROD_W'(SCALE);
      end
      BK_DIV: begin
        quo1_r <= CMP_W'(qprod1 >> RECIP_SH);
        quo2_r <= CMP_W'(qprod2 >> RECIP_SH);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == BK_HOLD && out_free) begin
      out_data_r <= {{PAD_W{1'b0}}, dither_r, quo2_r, quo1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == BK_HOLD && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

/* rtl/core/sine_dither_current_pwm_unit.sv */
// Path from input beat to output beat: queue, then
// sine lookup, dither multiply, clamp, duty multiply, reciprocal divide by 2500, hold.
// The back end works on one tick at a time and takes no new tick until the last one
// has left its hold state; the front takes up to two ticks ahead into its queue.
// Reset: synchronous, active low; clears phase, tick count, queue and output valid,
// and loads the register defaults.
`default_nettype none

module sine_dither_current_pwm_unit #(
  parameter int unsigned PWM_PERIOD = 1023
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [sdcp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  wire  [sdcp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // [11:0] ch1_setpoint, [23:12] ch2_setpoint
  input  wire  [sdcp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // [10:0] ch1_compare, [21:11] ch2_compare, [34:22] dither_value, [39:35] zero
  output logic [sdcp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sdcp_pkg::*;

  tick_entry_t      push_data;
  tick_entry_t      head_data;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  logic [AMP_W-1:0] dither_amp;

  sdcp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data),
    .dither_amp (dither_amp)
  );

  sdcp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (head_data)
  );

  sdcp_back #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dither_amp (dither_amp),
    .q_valid    (q_valid),
    .q_head     (head_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* rtl/core/sdcp_checker.sv */
// Port-level checks for the dither PWM unit and their binding to the top level.
`default_nettype none

module sdcp_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [sdcp_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sdcp_pkg::*;

  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output beat dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not empty the unit");

  a_dither_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[34:22]) >= -2500) && ($signed(out_tdata[34:22]) <= 2500))
    else $error("dither outside full scale");

endmodule

bind sine_dither_current_pwm_unit sdcp_checker u_sdcp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
